>>> hw/rtl/refcounted_page_allocator_top_defines.svh
// Assertion macros for the page allocator top level.
// Included by refcounted_page_allocator_top; expects clk_i and rst_ni in scope.
`ifndef REFCOUNTED_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_TOP_DEFINES_SVH

// Check a plain property on every clock edge outside reset.
`define RCPA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define RCPA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define RCPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/rcpa_pkg.sv
// Shared types and constants of the reference-counted page allocator.
// No dependencies; used by rcpa_engine and refcounted_page_allocator_top.
package rcpa_pkg;

  localparam int unsigned NumPagesDef  = 4096;
  localparam int unsigned PageShiftDef = 12;
  localparam int unsigned CountBitsDef = 8;

  localparam int unsigned AddrW    = 24;
  localparam int unsigned FirstW   = 12;
  localparam int unsigned LimitW   = 13;
  localparam int unsigned FreeW    = 13;
  localparam int unsigned RcOutW   = 8;
  localparam int unsigned CfgDataW = 13;

  localparam logic [FirstW-1:0] FirstUsableRst = '0;
  localparam logic [LimitW-1:0] PageLimitRst   = 13'd4096;

  localparam logic REG_FIRST_USABLE = 1'b0;
  localparam logic REG_PAGE_LIMIT   = 1'b1;

  typedef enum logic [2:0] {
    CMD_SEED     = 3'd0,
    CMD_FREE     = 3'd1,
    CMD_ALLOC    = 3'd2,
    CMD_INC_REF  = 3'd3,
    CMD_DEC_REF  = 3'd4,
    CMD_GET_REF  = 3'd5,
    CMD_GET_FREE = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ADDR = 2'd1,
    ST_NO_MEM   = 2'd2,
    ST_SAT      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_EXEC
  } fsm_e;

  typedef struct packed {
    status_e           status;
    logic [AddrW-1:0]  result_addr;
    logic [RcOutW-1:0] page_refs;
    logic [FreeW-1:0]  free_total;
  } result_t;

  typedef struct packed {
    logic [FirstW-1:0] first_usable;
    logic [LimitW-1:0] page_limit;
  } cfg_t;

endpackage

>>> hw/rtl/rcpa_engine.sv
// Command engine: count table and free-page stack memories, read-modify-write.
// Depends on rcpa_pkg.
module rcpa_engine #(
  parameter int unsigned NUM_PAGES  = rcpa_pkg::NumPagesDef,
  parameter int unsigned PAGE_SHIFT = rcpa_pkg::PageShiftDef,
  parameter int unsigned COUNT_BITS = rcpa_pkg::CountBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  output logic                         req_ready_o,
  input  logic [2:0]                   cmd_i,
  input  logic [rcpa_pkg::AddrW-1:0]   addr_i,
  input  rcpa_pkg::cfg_t               cfg_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output rcpa_pkg::result_t            res_o
);

  localparam int unsigned IDX_W = $clog2(NUM_PAGES);
  localparam int unsigned FC_W  = $clog2(NUM_PAGES + 1);
  localparam logic [rcpa_pkg::AddrW-1:0] OFF_MASK =
    rcpa_pkg::AddrW'((64'd1 << PAGE_SHIFT) - 64'd1);
  localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(NUM_PAGES - 1);
  localparam logic [FC_W-1:0]       FC_FULL   = FC_W'(NUM_PAGES);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  rcpa_pkg::fsm_e state_q, state_d;
  logic [IDX_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [FC_W-1:0]  fc_q, fc_d;

  logic [2:0]       cmd_q;
  logic [IDX_W-1:0] idx_q;
  logic             in_table_q, range_ok_q;

  logic [COUNT_BITS-1:0] ref_mem [NUM_PAGES];
  logic [IDX_W-1:0]      stack_mem [NUM_PAGES];
  logic [COUNT_BITS-1:0] ref_rdata_q;
  logic [IDX_W-1:0]      stack_rdata_q;

  logic                  accept, advance, clearing;
  logic [31:0]           pidx32;
  logic                  in_table, range_ok;
  logic [FC_W-1:0]       fc_dec;

  logic                  ref_we, ref_we_x, stack_we, stack_we_x;
  logic [IDX_W-1:0]      ref_waddr, ref_waddr_x;
  logic [COUNT_BITS-1:0] ref_wdata, ref_wdata_x;
  logic [COUNT_BITS-1:0] base_cnt, new_cnt, rc_src;
  logic                  rc_en;
  logic [32:0]           rc_ext, fc_ext;
  logic [31:0]           pop_addr;
  rcpa_pkg::status_e     status;
  logic [rcpa_pkg::AddrW-1:0] raddr;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rcpa_pkg::FSM_CLEAR: begin
        if (clr_cnt_q == LAST_IDX) state_d = rcpa_pkg::FSM_IDLE;
      end
      rcpa_pkg::FSM_IDLE: begin
        if (req_valid_i) state_d = rcpa_pkg::FSM_EXEC;
      end
      rcpa_pkg::FSM_EXEC: begin
        if (res_ready_i) state_d = rcpa_pkg::FSM_IDLE;
      end
      default: state_d = rcpa_pkg::FSM_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    clearing    = 1'b0;
    unique case (state_q)
      rcpa_pkg::FSM_CLEAR: clearing    = 1'b1;
      rcpa_pkg::FSM_IDLE:  req_ready_o = 1'b1;
      rcpa_pkg::FSM_EXEC:  res_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign accept    = req_valid_i && req_ready_o;
  assign advance   = res_valid_o && res_ready_i;
  assign clr_cnt_d = clearing ? clr_cnt_q + 1'b1 : clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rcpa_pkg::FSM_CLEAR;
      clr_cnt_q <= '0;
      fc_q      <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      fc_q      <= fc_d;
    end
  end

  // Address checks on the incoming item
  assign pidx32   = {8'b0, addr_i} >> PAGE_SHIFT;
  assign in_table = pidx32 < 32'(NUM_PAGES);
  assign range_ok = ((addr_i & OFF_MASK) == '0)
                 && (pidx32 >= {20'b0, cfg_i.first_usable})
                 && (pidx32 < {19'b0, cfg_i.page_limit})
                 && in_table;
  assign fc_dec   = fc_q - 1'b1;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= cmd_i;
      idx_q      <= pidx32[IDX_W-1:0];
      in_table_q <= in_table;
      range_ok_q <= range_ok;
    end
  end

  // Memories: read on accept, write back on advance or during the clear pass
  always_ff @(posedge clk_i) begin
    if (ref_we) ref_mem[ref_waddr] <= ref_wdata;
    if (accept) ref_rdata_q <= ref_mem[pidx32[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) stack_mem[fc_q[IDX_W-1:0]] <= idx_q;
    if (accept) stack_rdata_q <= stack_mem[fc_dec[IDX_W-1:0]];
  end

  // Modify
  assign base_cnt = (cmd_q == rcpa_pkg::CMD_SEED) ? '0 : ref_rdata_q;
  assign new_cnt  = (base_cnt != '0) ? base_cnt - 1'b1 : '0;
  assign pop_addr = 32'(stack_rdata_q) << PAGE_SHIFT;

  always_comb begin
    status      = rcpa_pkg::ST_OK;
    raddr       = '0;
    rc_src      = '0;
    rc_en       = 1'b0;
    ref_we_x    = 1'b0;
    ref_waddr_x = idx_q;
    ref_wdata_x = '0;
    stack_we_x  = 1'b0;
    fc_d        = fc_q;
    unique case (cmd_q) inside
      rcpa_pkg::CMD_SEED, rcpa_pkg::CMD_FREE: begin
        if (!range_ok_q) begin
          status = rcpa_pkg::ST_BAD_ADDR;
        end else begin
          ref_we_x    = 1'b1;
          ref_wdata_x = new_cnt;
          rc_src      = new_cnt;
          rc_en       = 1'b1;
          if (new_cnt == '0) begin
            if (fc_q == FC_FULL) begin
              status = rcpa_pkg::ST_SAT;
            end else begin
              stack_we_x = 1'b1;
              fc_d       = fc_q + 1'b1;
            end
          end
        end
      end
      rcpa_pkg::CMD_ALLOC: begin
        if (fc_q == '0) begin
          status = rcpa_pkg::ST_NO_MEM;
        end else begin
          fc_d        = fc_dec;
          ref_we_x    = 1'b1;
          ref_waddr_x = stack_rdata_q;
          ref_wdata_x = COUNT_BITS'(1);
          raddr       = pop_addr[rcpa_pkg::AddrW-1:0];
          rc_src      = COUNT_BITS'(1);
          rc_en       = 1'b1;
        end
      end
      rcpa_pkg::CMD_INC_REF: begin
        if (!in_table_q) begin
          status = rcpa_pkg::ST_BAD_ADDR;
        end else begin
          rc_en = 1'b1;
          if (ref_rdata_q == COUNT_MAX) begin
            status = rcpa_pkg::ST_SAT;
            rc_src = ref_rdata_q;
          end else begin
            ref_we_x    = 1'b1;
            ref_wdata_x = ref_rdata_q + 1'b1;
            rc_src      = ref_rdata_q + 1'b1;
          end
        end
      end
      rcpa_pkg::CMD_DEC_REF: begin
        if (!in_table_q) begin
          status = rcpa_pkg::ST_BAD_ADDR;
        end else begin
          rc_en = 1'b1;
          if (ref_rdata_q == '0) begin
            status = rcpa_pkg::ST_SAT;
            rc_src = '0;
          end else begin
            ref_we_x    = 1'b1;
            ref_wdata_x = ref_rdata_q - 1'b1;
            rc_src      = ref_rdata_q - 1'b1;
          end
        end
      end
      rcpa_pkg::CMD_GET_REF: begin
        if (!in_table_q) begin
          status = rcpa_pkg::ST_BAD_ADDR;
        end else begin
          rc_en  = 1'b1;
          rc_src = ref_rdata_q;
        end
      end
      default: ;
    endcase
    if (!advance) begin
      ref_we_x   = 1'b0;
      stack_we_x = 1'b0;
      fc_d       = fc_q;
    end
  end

  assign ref_we    = clearing || ref_we_x;
  assign ref_waddr = clearing ? clr_cnt_q : ref_waddr_x;
  assign ref_wdata = clearing ? '0 : ref_wdata_x;
  assign stack_we  = stack_we_x;

  assign rc_ext = {{(33 - COUNT_BITS){1'b0}}, rc_src};
  assign fc_ext = {{(33 - FC_W){1'b0}}, fc_d};

  always_comb begin
    res_o.status      = status;
    res_o.result_addr = raddr;
    res_o.page_refs   = !rc_en ? '0 :
                        (rc_ext > 33'd255) ? 8'hFF : rc_ext[rcpa_pkg::RcOutW-1:0];
    res_o.free_total  = fc_ext[rcpa_pkg::FreeW-1:0];
  end

endmodule

>>> hw/rtl/refcounted_page_allocator_top.sv
// Top level of the reference-counted page allocator: config registers, result register.
// Depends on rcpa_pkg, rcpa_engine and refcounted_page_allocator_top_defines.svh.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-----------------------------------------
//   in       | in_valid_i / in_ready_o   | cmd_i, page_addr_i
//   out      | out_valid_o / out_ready_i | status_o, result_addr_o, page_refs_o,
//            |                           | free_total_o
//   cfg      | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// Each item goes through the IDLE and EXEC states: IDLE reads the count table and stack
// on accept, EXEC modifies and writes back; the single port of each memory sets this split.
// After reset the count table is zeroed, one entry a cycle, across all NUM_PAGES entries;
// in_ready_o stays low until that ends.
// A result waits in the output register; the next item is accepted meanwhile and
// holds in its write-back cycle while that register stays full.
`include "refcounted_page_allocator_top_defines.svh"

module refcounted_page_allocator_top #(
  parameter int unsigned NUM_PAGES  = rcpa_pkg::NumPagesDef,
  parameter int unsigned PAGE_SHIFT = rcpa_pkg::PageShiftDef,
  parameter int unsigned COUNT_BITS = rcpa_pkg::CountBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [2:0]                     cmd_i,
  input  logic [rcpa_pkg::AddrW-1:0]     page_addr_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     status_o,
  output logic [rcpa_pkg::AddrW-1:0]     result_addr_o,
  output logic [rcpa_pkg::RcOutW-1:0]    page_refs_o,
  output logic [rcpa_pkg::FreeW-1:0]     free_total_o,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [rcpa_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  rcpa_pkg::cfg_t    cfg_q, cfg_d;
  rcpa_pkg::result_t res, out_q;
  logic              res_valid, res_ready;
  logic              out_valid_q, out_valid_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rcpa_pkg::REG_FIRST_USABLE: cfg_d.first_usable = cfg_wdata_i[rcpa_pkg::FirstW-1:0];
        rcpa_pkg::REG_PAGE_LIMIT:   cfg_d.page_limit   = cfg_wdata_i[rcpa_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_usable <= rcpa_pkg::FirstUsableRst;
      cfg_q.page_limit   <= rcpa_pkg::PageLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rcpa_engine #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .COUNT_BITS (COUNT_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .cmd_i       (cmd_i),
    .addr_i      (page_addr_i),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register
  assign res_ready   = !out_valid_q || out_ready_i;
  assign out_valid_d = res_valid ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign result_addr_o = out_q.result_addr;
  assign page_refs_o   = out_q.page_refs;
  assign free_total_o  = out_q.free_total;

  `RCPA_ASSERT_NEXT(a_one_item_in_flight, in_valid_i && in_ready_o, !in_ready_o,
    "item accepted while engine busy")
  `RCPA_ASSERT_IMP(a_bad_addr_clean, out_valid_o && (status_o == rcpa_pkg::ST_BAD_ADDR),
    (page_refs_o == '0) && (result_addr_o == '0), "bad address result carries data")
  `RCPA_ASSERT_IMP(a_alloc_count_one,
    out_valid_o && (status_o == rcpa_pkg::ST_OK) && (result_addr_o != '0),
    page_refs_o == 8'd1, "allocated page count is not one")
  `RCPA_ASSERT(a_free_bound, !out_valid_o || ({20'b0, free_total_o} <= 33'(NUM_PAGES)),
    "free total above page count")

endmodule

>>> bench/refcounted_page_allocator_top_test.sv
// Self-checking bench for refcounted_page_allocator_top: commands go in on a valid/ready
// channel, results are predicted by a page book class and compared field by field.
// Depends on rcpa_pkg and the refcounted_page_allocator_top RTL.
module refcounted_page_allocator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  CmdUnused     = 3'd7;
  localparam int unsigned CountMax      = (1 << rcpa_pkg::CountBitsDef) - 1;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned CycleLimit    = 400000;

  typedef enum {PR_NONE, PR_HOLD, PR_DRAIN} pressure_e;

  class PageBook;
    int unsigned                 page_counts [rcpa_pkg::NumPagesDef];
    logic [rcpa_pkg::FirstW-1:0] page_stack [rcpa_pkg::NumPagesDef];
    int unsigned                 stack_depth;
    int unsigned                 first_usable;
    int unsigned                 page_limit;
    logic [rcpa_pkg::AddrW-1:0]  last_taken;
    rcpa_pkg::result_t           due_results [$];
    int unsigned                 mismatches;

    function new();
      foreach (page_counts[i]) page_counts[i] = 0;
      stack_depth  = 0;
      first_usable = rcpa_pkg::FirstUsableRst;
      page_limit   = rcpa_pkg::PageLimitRst;
      last_taken   = '0;
      mismatches   = 0;
    endfunction

    function void set_window(int unsigned first, int unsigned limit);
      first_usable = first & 32'hFFF;
      page_limit   = limit & 32'h1FFF;
    endfunction

    function rcpa_pkg::status_e release_page(int unsigned idx);
      if (page_counts[idx] > 0) page_counts[idx]--;
      if (page_counts[idx] == 0) begin
        if (stack_depth >= rcpa_pkg::NumPagesDef) return rcpa_pkg::ST_SAT;
        page_stack[stack_depth] = rcpa_pkg::FirstW'(idx);
        stack_depth++;
      end
      return rcpa_pkg::ST_OK;
    endfunction

    function void take_cmd(logic [2:0] cmd, logic [rcpa_pkg::AddrW-1:0] addr);
      rcpa_pkg::result_t want;
      int unsigned       idx;
      want = '0;
      idx  = addr >> rcpa_pkg::PageShiftDef;
      case (cmd) inside
        rcpa_pkg::CMD_SEED, rcpa_pkg::CMD_FREE: begin
          if (addr[rcpa_pkg::PageShiftDef-1:0] != '0 || idx < first_usable ||
              idx >= page_limit || idx >= rcpa_pkg::NumPagesDef) begin
            want.status = rcpa_pkg::ST_BAD_ADDR;
          end else begin
            if (cmd == rcpa_pkg::CMD_SEED) page_counts[idx] = 0;
            want.status    = release_page(idx);
            want.page_refs = rcpa_pkg::RcOutW'(page_counts[idx]);
          end
        end
        rcpa_pkg::CMD_ALLOC: begin
          if (stack_depth == 0) begin
            want.status = rcpa_pkg::ST_NO_MEM;
          end else begin
            stack_depth--;
            idx = page_stack[stack_depth];
            page_counts[idx] = 1;
            want.result_addr = rcpa_pkg::AddrW'(idx << rcpa_pkg::PageShiftDef);
            want.page_refs   = 8'd1;
            last_taken       = want.result_addr;
          end
        end
        rcpa_pkg::CMD_INC_REF: begin
          if (page_counts[idx] >= CountMax) want.status = rcpa_pkg::ST_SAT;
          else page_counts[idx]++;
          want.page_refs = rcpa_pkg::RcOutW'(page_counts[idx]);
        end
        rcpa_pkg::CMD_DEC_REF: begin
          if (page_counts[idx] == 0) want.status = rcpa_pkg::ST_SAT;
          else page_counts[idx]--;
          want.page_refs = rcpa_pkg::RcOutW'(page_counts[idx]);
        end
        rcpa_pkg::CMD_GET_REF: want.page_refs = rcpa_pkg::RcOutW'(page_counts[idx]);
        default: ;
      endcase
      want.free_total = rcpa_pkg::FreeW'(stack_depth);
      due_results.push_back(want);
    endfunction

    function void match_result(logic [1:0] st, logic [rcpa_pkg::AddrW-1:0] ra,
                               logic [rcpa_pkg::RcOutW-1:0] rc,
                               logic [rcpa_pkg::FreeW-1:0] fp);
      rcpa_pkg::result_t want;
      if (due_results.size() == 0) begin
        $error("result with no item pending: status %0d addr %h", st, ra);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      if (st !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, st);
        mismatches++;
      end
      if (ra !== want.result_addr) begin
        $error("result_addr: expected %h, got %h", want.result_addr, ra);
        mismatches++;
      end
      if (rc !== want.page_refs) begin
        $error("page_refs: expected %0d, got %0d", want.page_refs, rc);
        mismatches++;
      end
      if (fp !== want.free_total) begin
        $error("free_total: expected %0d, got %0d", want.free_total, fp);
        mismatches++;
      end
    endfunction
  endclass

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  logic [2:0]                    cmd_i       = '0;
  logic [rcpa_pkg::AddrW-1:0]    page_addr_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [1:0]                    status_o;
  logic [rcpa_pkg::AddrW-1:0]    result_addr_o;
  logic [rcpa_pkg::RcOutW-1:0]   page_refs_o;
  logic [rcpa_pkg::FreeW-1:0]    free_total_o;
  logic                          cfg_we_i    = 1'b0;
  logic                          cfg_idx_i   = 1'b0;
  logic [rcpa_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  PageBook                     pages;
  bit                          tx_idle;
  bit                          rx_idle;
  bit                          rx_hold_req;
  logic [rcpa_pkg::FirstW-1:0] hot_pages [6];
  int unsigned                 cycle_count;

  refcounted_page_allocator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .page_addr_i   (page_addr_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .result_addr_o (result_addr_o),
    .page_refs_o   (page_refs_o),
    .free_total_o  (free_total_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        pages.match_result(status_o, result_addr_o, page_refs_o, free_total_o);
      end
      if (rx_hold_req) begin
        stall_left  = HoldOffCycles;
        rx_hold_req = 1'b0;
      end else if (stall_left == 0 && rx_idle) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic offer_cmd(logic [2:0] cmd, logic [rcpa_pkg::AddrW-1:0] addr);
    int unsigned gap;
    gap = tx_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    page_addr_i <= addr;
    do @(posedge clk_i); while (!in_ready_o);
    pages.take_cmd(cmd, addr);
  endtask

  task automatic offer_random_cmd();
    logic [2:0]                 cmd;
    logic [rcpa_pkg::AddrW-1:0] addr;
    int unsigned                r;
    r = $urandom_range(0, 99);
    if (r < 10) cmd = rcpa_pkg::CMD_SEED;
    else if (r < 28) cmd = rcpa_pkg::CMD_FREE;
    else if (r < 48) cmd = rcpa_pkg::CMD_ALLOC;
    else if (r < 66) cmd = rcpa_pkg::CMD_INC_REF;
    else if (r < 78) cmd = rcpa_pkg::CMD_DEC_REF;
    else if (r < 88) cmd = rcpa_pkg::CMD_GET_REF;
    else if (r < 95) cmd = rcpa_pkg::CMD_GET_FREE;
    else cmd = CmdUnused;
    r = $urandom_range(0, 99);
    if (r < 30) addr = pages.last_taken;
    else if (r < 75) addr = {hot_pages[$urandom_range(0, 5)], 12'h000};
    else if (r < 85) begin
      addr = {rcpa_pkg::FirstW'($urandom_range(0, rcpa_pkg::NumPagesDef - 1)), 12'h000};
    end else addr = rcpa_pkg::AddrW'($urandom());
    if ((cmd == rcpa_pkg::CMD_INC_REF || cmd == rcpa_pkg::CMD_DEC_REF ||
         cmd == rcpa_pkg::CMD_GET_REF) && $urandom_range(0, 2) == 0) begin
      addr[rcpa_pkg::PageShiftDef-1:0] = rcpa_pkg::PageShiftDef'($urandom());
    end
    offer_cmd(cmd, addr);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pages.due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_window(int unsigned first, int unsigned limit);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= rcpa_pkg::REG_FIRST_USABLE;
    cfg_wdata_i <= rcpa_pkg::CfgDataW'(first);
    @(posedge clk_i);
    cfg_idx_i   <= rcpa_pkg::REG_PAGE_LIMIT;
    cfg_wdata_i <= rcpa_pkg::CfgDataW'(limit);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pages.set_window(first, limit);
  endtask

  task automatic run_phase(int unsigned first, int unsigned limit, int n, bit tx, bit rx,
                           pressure_e pr);
    int unsigned top;
    int          i;
    wait_drained();
    apply_window(first, limit);
    tx_idle = tx;
    rx_idle = rx;
    top = (limit > rcpa_pkg::NumPagesDef) ? rcpa_pkg::NumPagesDef : limit;
    for (i = 0; i < 6; i++) begin
      if (first < top) begin
        hot_pages[i] = rcpa_pkg::FirstW'(first + $urandom_range(0, top - first - 1));
      end else begin
        hot_pages[i] = rcpa_pkg::FirstW'($urandom_range(0, rcpa_pkg::NumPagesDef - 1));
      end
    end
    if (first < top) begin
      hot_pages[0] = rcpa_pkg::FirstW'(first);
      hot_pages[1] = rcpa_pkg::FirstW'(top - 1);
    end
    for (i = 0; i < n; i++) begin
      if (pr == PR_HOLD && i == n / 3) rx_hold_req = 1'b1;
      if (pr == PR_DRAIN && i == n / 2) wait_drained();
      offer_random_cmd();
    end
  endtask

  initial begin : stimulus
    int i;
    pages   = new();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    apply_window(0, 4096);
    offer_cmd(rcpa_pkg::CMD_GET_FREE, 24'h000000);
    offer_cmd(rcpa_pkg::CMD_ALLOC,    24'h000000);
    offer_cmd(rcpa_pkg::CMD_DEC_REF,  24'h005000);
    offer_cmd(rcpa_pkg::CMD_SEED,     24'h000000);
    offer_cmd(rcpa_pkg::CMD_SEED,     24'hFFF000);
    offer_cmd(rcpa_pkg::CMD_SEED,     24'h003001);
    offer_cmd(rcpa_pkg::CMD_FREE,     24'h004800);
    offer_cmd(rcpa_pkg::CMD_GET_REF,  24'hFFFFFF);
    offer_cmd(rcpa_pkg::CMD_INC_REF,  24'h005ABC);
    offer_cmd(rcpa_pkg::CMD_INC_REF,  24'h005000);
    offer_cmd(rcpa_pkg::CMD_FREE,     24'h005000);
    offer_cmd(rcpa_pkg::CMD_FREE,     24'h005000);
    offer_cmd(rcpa_pkg::CMD_FREE,     24'h005000);
    offer_cmd(rcpa_pkg::CMD_GET_FREE, 24'hFFFFFF);
    offer_cmd(rcpa_pkg::CMD_ALLOC,    24'h000000);
    offer_cmd(rcpa_pkg::CMD_ALLOC,    24'h000000);
    offer_cmd(rcpa_pkg::CMD_ALLOC,    24'h000000);
    offer_cmd(rcpa_pkg::CMD_ALLOC,    24'h000000);
    offer_cmd(rcpa_pkg::CMD_ALLOC,    24'h000000);
    offer_cmd(CmdUnused,              24'hFFFFFF);
    offer_cmd(rcpa_pkg::CMD_DEC_REF,  24'h005000);
    offer_cmd(rcpa_pkg::CMD_GET_REF,  24'h000FFF);
    offer_cmd(rcpa_pkg::CMD_SEED,     24'h000000);
    wait_drained();
    apply_window(100, 200);
    offer_cmd(rcpa_pkg::CMD_SEED, 24'h063000);
    offer_cmd(rcpa_pkg::CMD_SEED, 24'h064000);
    offer_cmd(rcpa_pkg::CMD_FREE, 24'h0C7000);
    offer_cmd(rcpa_pkg::CMD_FREE, 24'h0C8000);

    run_phase(0, 4096, 24, 1'b1, 1'b1, PR_HOLD);
    run_phase(4095, 4096, 16, 1'b1, 1'b1, PR_DRAIN);
    run_phase(0, 1, 12, 1'b0, 1'b0, PR_NONE);
    run_phase(100, 200, 20, 1'b1, 1'b1, PR_NONE);
    run_phase(3000, 2000, 12, 1'b0, 1'b1, PR_NONE);
    run_phase($urandom_range(0, 4095), $urandom_range(1, 4096), 20, 1'b1, 1'b0, PR_NONE);

    run_phase(0, 4096, 0, 1'b0, 1'b0, PR_NONE);
    for (i = 0; i < 256; i++) offer_cmd(rcpa_pkg::CMD_INC_REF, 24'h007123);
    offer_cmd(rcpa_pkg::CMD_DEC_REF, 24'h007000);
    offer_cmd(rcpa_pkg::CMD_GET_REF, 24'h007FFF);

    offer_cmd(rcpa_pkg::CMD_SEED,     24'hFFF000);
    offer_cmd(rcpa_pkg::CMD_FREE,     24'hFFF000);
    offer_cmd(rcpa_pkg::CMD_SEED,     24'h000000);
    offer_cmd(rcpa_pkg::CMD_GET_FREE, 24'h000000);
    offer_cmd(rcpa_pkg::CMD_INC_REF,  24'hFFF000);
    offer_cmd(rcpa_pkg::CMD_FREE,     24'hFFF000);
    offer_cmd(rcpa_pkg::CMD_ALLOC,    24'h000000);
    offer_cmd(rcpa_pkg::CMD_FREE,     24'hFFF000);
    offer_cmd(rcpa_pkg::CMD_GET_FREE, 24'h000000);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (pages.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
